@@ rtl/core/eve_pkg.sv @@
// Shared types, widths and constants of the acceleration alpha block.
package eve_pkg;

    localparam int X_W             = 16;
    localparam int RATIO_W         = 24;
    localparam int ALPHA_W         = 16;
    localparam int LOG_FRAC_BITS   = 16;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int ALPHA_FRAC_BITS = 16;
    localparam int MANT_BITS       = 30;
    localparam int MANT_W          = MANT_BITS + 1;
    localparam int POS_W           = $clog2(RATIO_W);
    localparam int LMAG_W          = 21;
    localparam int LPROD_W         = 2 * LMAG_W - 1;
    localparam int LO_W            = 21;
    localparam int HI_W            = LPROD_W - LO_W;
    localparam int XSQ_W           = 2 * X_W;
    localparam int FULL_W          = XSQ_W + LPROD_W + 1;
    localparam int TERM_W          = FULL_W - LOG_FRAC_BITS;
    localparam int ACC_W           = 64;
    localparam int ITER_W          = 4;

    localparam logic [ALPHA_W-1:0] CAP_RESET = 16'd64225;
    localparam logic [ITER_W-1:0]  LOG_LAST  = ITER_W'(LOG_FRAC_BITS - 1);
    localparam logic [ITER_W-1:0]  DIV_LAST  = ITER_W'(ALPHA_FRAC_BITS - 1);

    typedef struct packed {
        logic [X_W-1:0]     x_now;
        logic [X_W-1:0]     x_prev;
        logic [RATIO_W-1:0] ratio_now;
        logic [RATIO_W-1:0] ratio_prev;
        logic               last_voxel;
    } t_in_word;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_raw;
        logic [ALPHA_W-1:0] alpha_damped;
        logic               zero_denominator;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_LOG, S_MULA, S_MULLO, S_MULHI, S_ACC, S_DINIT, S_DIV, S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic log_step;
        logic mul_a;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic div_init;
        logic div_step;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/eve_in_if.sv @@
// Input word channel: valid/ready handshake with voxel payload.
interface eve_in_if import eve_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/eve_out_if.sv @@
// Output word channel: valid/ready handshake with alpha payload.
interface eve_out_if import eve_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/eve_acceleration_alpha.sv @@
// Top level: acceleration alpha over a voxel stream.
// Each accepted voxel word runs log2 squaring, the MULA, MULLO and MULHI multiply steps
// and an accumulate step; the sequencer then returns to idle and takes the next word.
// A last voxel adds divider setup, the divider steps and a finish step that waits for a
// free output register; the result word then waits in an output register until taken.
// Synchronous active-low reset clears the sums and previous alpha, sets cap to 0.98.
module eve_acceleration_alpha import eve_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    eve_in_if.sink             i_in,
    eve_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [ALPHA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_state  state;

    eve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    eve_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> sts.out_free) else $error("result written over pending word");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.zero_denominator) |->
        (o_out.data.alpha_raw == '0 && o_out.data.alpha_damped == '0))
        else $error("zero denominator with nonzero alpha");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (state == S_LOG))
        else $error("accepted word did not start log");

endmodule

@@ rtl/core/eve_ctrl.sv @@
// Sequencer for log, multiply, accumulate and divide steps.
module eve_ctrl import eve_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output t_state  o_state
);

    t_state             r_state, n_state;
    logic [ITER_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOG;
                    n_cnt   = LOG_LAST;
                end
            end
            S_LOG: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_MULA;
            end
            S_MULA:  n_state = S_MULLO;
            S_MULLO: n_state = S_MULHI;
            S_MULHI: n_state = S_ACC;
            S_ACC:   n_state = i_sts.last ? S_DINIT : S_IDLE;
            S_DINIT: begin
                n_state = S_DIV;
                n_cnt   = DIV_LAST;
            end
            S_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_LOG:   o_cmd.log_step = 1'b1;
            S_MULA:  o_cmd.mul_a    = 1'b1;
            S_MULLO: o_cmd.mul_lo   = 1'b1;
            S_MULHI: o_cmd.mul_hi   = 1'b1;
            S_ACC:   o_cmd.acc      = 1'b1;
            S_DINIT: o_cmd.div_init = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_FIN:   o_cmd.fin      = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_state = r_state;

endmodule

@@ rtl/core/eve_dp.sv @@
// Datapath: log2 by squaring, term products, saturating sums, divider, output.
module eve_dp import eve_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_in_word           i_word,
    input  logic               i_cfg_we,
    input  logic [ALPHA_W-1:0] i_cfg_data,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_data
);

    logic [ALPHA_W-1:0]       r_cap;
    logic [X_W-1:0]           r_xn, r_xp;
    logic                     r_last, r_use;
    logic [POS_W-1:0]         r_pn, r_pp;
    logic [MANT_W-1:0]        r_mn, r_mp;
    logic [LOG_FRAC_BITS-1:0] r_fn, r_fp;
    logic [LPROD_W-1:0]       r_ln, r_ld;
    logic                     r_neg;
    logic [XSQ_W-1:0]         r_sqn, r_sqp;
    logic [XSQ_W+LO_W-1:0]    r_pn_lo, r_pd_lo;
    logic [XSQ_W+HI_W-1:0]    r_pn_hi, r_pd_hi;
    logic [ACC_W-1:0]         r_num, r_den;
    logic [ACC_W-1:0]         r_rem;
    logic [ALPHA_W-1:0]       r_q;
    logic                     r_zden, r_nonpos, r_ge;
    logic [ALPHA_W-1:0]       r_prev;
    logic                     r_out_valid;
    t_out_word                r_out;

    function automatic logic [POS_W-1:0] lead_one(input logic [RATIO_W-1:0] r);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 1; i < RATIO_W; i++) begin
            if (r[i]) p = POS_W'(i);
        end
        return p;
    endfunction

    function automatic logic [MANT_W-1:0] norm(input logic [RATIO_W-1:0] r,
                                               input logic [POS_W-1:0] p);
        logic [MANT_W-1:0] m;
        m = MANT_W'(r) << (POS_W'(MANT_BITS) - p);
        return m;
    endfunction

    function automatic logic [LMAG_W-1:0] log_mag(input logic [POS_W-1:0] p,
                                                 input logic [LOG_FRAC_BITS-1:0] f);
        logic [LMAG_W-1:0] m;
        if (p >= POS_W'(RATIO_FRAC_BITS))
            m = (LMAG_W'(p - POS_W'(RATIO_FRAC_BITS)) << LOG_FRAC_BITS) + LMAG_W'(f);
        else
            m = (LMAG_W'(POS_W'(RATIO_FRAC_BITS) - p) << LOG_FRAC_BITS) - LMAG_W'(f);
        return m;
    endfunction

    logic [2*MANT_W-1:0] sq_n, sq_p;
    logic [MANT_W:0]     m2_n, m2_p;
    logic [LMAG_W-1:0]   mag_n, mag_p;

    assign sq_n  = r_mn * r_mn;
    assign sq_p  = r_mp * r_mp;
    assign m2_n  = sq_n[MANT_BITS +: MANT_W+1];
    assign m2_p  = sq_p[MANT_BITS +: MANT_W+1];
    assign mag_n = log_mag(r_pn, r_fn);
    assign mag_p = log_mag(r_pp, r_fp);

    logic [FULL_W-1:0]  full_n, full_d;
    logic [TERM_W-1:0]  term_n, term_d;
    logic [ACC_W:0]     add_n, sum_n, sum_d;

    assign full_n = FULL_W'(r_pn_lo) + (FULL_W'(r_pn_hi) << LO_W);
    assign full_d = FULL_W'(r_pd_lo) + (FULL_W'(r_pd_hi) << LO_W);
    assign term_n = full_n[FULL_W-1:LOG_FRAC_BITS];
    assign term_d = full_d[FULL_W-1:LOG_FRAC_BITS];
    assign add_n  = r_neg ? ((ACC_W+1)'(0) - (ACC_W+1)'(term_n)) : (ACC_W+1)'(term_n);
    assign sum_n  = {r_num[ACC_W-1], r_num} + add_n;
    assign sum_d  = {r_den[ACC_W-1], r_den} + (ACC_W+1)'(term_d);

    function automatic logic [ACC_W-1:0] sat(input logic [ACC_W:0] s);
        logic [ACC_W-1:0] v;
        if (s[ACC_W] != s[ACC_W-1])
            v = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            v = s[ACC_W-1:0];
        return v;
    endfunction

    logic [ACC_W:0]       div_t, div_s;
    logic [ALPHA_W-1:0]   raw;
    logic [2*ALPHA_W-1:0] raw_sq;
    logic [ALPHA_W-1:0]   sqv;
    logic [ALPHA_W:0]     avg;
    logic [ALPHA_W-1:0]   damped;

    assign div_t  = {r_rem, 1'b0};
    assign div_s  = div_t - {1'b0, r_den};
    assign raw    = (r_zden || r_nonpos) ? '0 :
                    (r_ge || r_q > r_cap) ? r_cap : r_q;
    assign raw_sq = raw * raw;
    assign sqv    = raw_sq[ALPHA_FRAC_BITS +: ALPHA_W];
    assign avg    = (ALPHA_W+1)'(sqv) + (ALPHA_W+1)'(r_prev);
    assign damped = (sqv > r_prev) ? avg[ALPHA_W:1] : sqv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_num       <= '0;
            r_den       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.acc && r_use) begin
                r_num <= sat(sum_n);
                r_den <= sat(sum_d);
            end
            if (i_cmd.fin) begin
                r_num       <= '0;
                r_den       <= '0;
                r_prev      <= r_zden ? '0 : damped;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xn   <= i_word.x_now;
            r_xp   <= i_word.x_prev;
            r_last <= i_word.last_voxel;
            r_use  <= (i_word.ratio_now != '0) && (i_word.ratio_prev != '0);
            r_pn   <= lead_one(i_word.ratio_now);
            r_pp   <= lead_one(i_word.ratio_prev);
            r_mn   <= norm(i_word.ratio_now, lead_one(i_word.ratio_now));
            r_mp   <= norm(i_word.ratio_prev, lead_one(i_word.ratio_prev));
            r_fn   <= '0;
            r_fp   <= '0;
        end
        if (i_cmd.log_step) begin
            r_mn <= m2_n[MANT_W] ? m2_n[MANT_W:1] : m2_n[MANT_W-1:0];
            r_mp <= m2_p[MANT_W] ? m2_p[MANT_W:1] : m2_p[MANT_W-1:0];
            r_fn <= {r_fn[LOG_FRAC_BITS-2:0], m2_n[MANT_W]};
            r_fp <= {r_fp[LOG_FRAC_BITS-2:0], m2_p[MANT_W]};
        end
        if (i_cmd.mul_a) begin
            r_ln  <= mag_n * mag_p;
            r_ld  <= mag_p * mag_p;
            r_neg <= (r_pn < POS_W'(RATIO_FRAC_BITS)) != (r_pp < POS_W'(RATIO_FRAC_BITS));
            r_sqn <= r_xn * r_xn;
            r_sqp <= r_xp * r_xp;
        end
        if (i_cmd.mul_lo) begin
            r_pn_lo <= r_sqn * r_ln[LO_W-1:0];
            r_pd_lo <= r_sqp * r_ld[LO_W-1:0];
        end
        if (i_cmd.mul_hi) begin
            r_pn_hi <= r_sqn * r_ln[LPROD_W-1:LO_W];
            r_pd_hi <= r_sqp * r_ld[LPROD_W-1:LO_W];
        end
        if (i_cmd.div_init) begin
            r_zden   <= (r_den == '0);
            r_nonpos <= r_num[ACC_W-1] || (r_num == '0);
            r_ge     <= (r_num >= r_den);
            r_rem    <= r_num;
            r_q      <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_s[ACC_W] ? div_t[ACC_W-1:0] : div_s[ACC_W-1:0];
            r_q   <= {r_q[ALPHA_W-2:0], !div_s[ACC_W]};
        end
        if (i_cmd.fin) begin
            r_out.alpha_raw        <= raw;
            r_out.alpha_damped     <= r_zden ? '0 : damped;
            r_out.zero_denominator <= r_zden;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule
